FILE: rtl/rmq_pkg.sv
// ----------------------------------------------------------------------------
// rmq_pkg
// Shared constants for the rotation-matrix-to-quaternion unit.
// ----------------------------------------------------------------------------
package rmq_pkg;

    // default element format: Q2.14 in 16 bits
    localparam int DATA_WIDTH_DEF = 16;
    localparam int FRAC_BITS_DEF  = 14;

    // which quaternion component carries the square-root term
    localparam logic [1:0] BIG_W = 2'd0;
    localparam logic [1:0] BIG_X = 2'd1;
    localparam logic [1:0] BIG_Y = 2'd2;
    localparam logic [1:0] BIG_Z = 2'd3;

endpackage

FILE: rtl/rotation_matrix_to_quaternion_unit.sv
// ----------------------------------------------------------------------------
// rotation_matrix_to_quaternion_unit
// Converts a 3x3 rotation matrix into a unit quaternion (Shepperd's method).
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream carries one matrix per request: nine signed fixed-point
//   elements m00..m22 in tdata. Master stream returns one quaternion per
//   request (w, x, y, z in tdata) and the degenerate flag in tuser.
//   A request passes the input register, RTW square-root stages with
//   RTW = ceil((DATA_WIDTH+1+FRAC_BITS)/2), DVW divider stages with
//   DVW = DATA_WIDTH+FRAC_BITS+2 and the output register (Q2.14 by default).
//   Throughput: one request per cycle while the receiver does not stall;
//   the root and the three quotients (in parallel lanes) gain one bit per stage.
//   Reset (synchronous, active low) clears every stage valid bit.
//   When the receiver stalls, the whole pipeline holds in place and
//   s_axis_tready drops; the output register is refilled as soon as the
//   held result is taken.
// ----------------------------------------------------------------------------
module rotation_matrix_to_quaternion_unit #(
    parameter int DATA_WIDTH = rmq_pkg::DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = rmq_pkg::FRAC_BITS_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    // m00,m01,m02,m10,m11,m12,m20,m21,m22 from bit 0 up, zero padded
    input  logic                                    s_axis_tvalid,
    output logic                                    s_axis_tready,
    input  logic [((9*DATA_WIDTH+7)/8)*8-1:0]       s_axis_tdata,
    // q_w,q_x,q_y,q_z from bit 0 up, zero padded
    output logic                                    m_axis_tvalid,
    input  logic                                    m_axis_tready,
    output logic [((4*DATA_WIDTH+7)/8)*8-1:0]       m_axis_tdata,
    // degenerate
    output logic                                    m_axis_tuser
);
    import rmq_pkg::*;

    localparam int DW   = DATA_WIDTH;
    localparam int FB   = FRAC_BITS;
    localparam int OBW  = ((4*DW+7)/8)*8;
    localparam int TW   = DW + 2;              // trace / radicand, signed
    localparam int RW   = DW + 1;              // positive radicand
    localparam int RTW  = (RW + FB + 1) / 2;   // root width
    localparam int SWE  = 2 * RTW;             // root input width
    localparam int REMS = RTW + 2;
    localparam int NW   = DW + 1;              // numerator, signed
    localparam int DVW  = NW + FB + 1;         // dividend / quotient
    localparam int DSW  = RTW + 1;             // divisor
    localparam int REMD = RTW + 2;

    localparam logic signed [TW-1:0] ONE     = TW'(1) << FB;
    localparam logic [DVW-1:0]       SAT_POS = (DVW'(1) << (DW-1)) - DVW'(1);
    localparam logic [DVW-1:0]       SAT_NEG = DVW'(1) << (DW-1);

    typedef struct packed {
        logic [1:0]             big;
        logic                   degen;
        logic signed [NW-1:0]   n0;
        logic signed [NW-1:0]   n1;
        logic signed [NW-1:0]   n2;
    } t_side;

    typedef struct packed {
        logic [1:0]     big;
        logic           degen;
        logic [DW-1:0]  big_val;
        logic [2:0]     neg;
    } t_dside;

    // global advance: output register empty or being taken
    logic w_adv;
    assign w_adv = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = w_adv;

    // ---------------- stage A: input register ----------------
    logic                  r_a_valid;
    logic signed [DW-1:0]  r_a_m [0:8];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (w_adv) begin
            r_a_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            for (int f = 0; f < 9; f++) begin
                r_a_m[f] <= s_axis_tdata[f*DW +: DW];
            end
        end
    end

    // ---------------- stage B: case select, radicand, numerators ----------------
    logic signed [TW-1:0] w_e00, w_e11, w_e22, w_trace, w_rad;
    logic signed [NW-1:0] w_m01, w_m02, w_m10, w_m12, w_m20, w_m21;
    t_side                n_b_side;
    logic [SWE-1:0]       n_b_x;

    always_comb begin
        w_e00 = TW'(r_a_m[0]);
        w_e11 = TW'(r_a_m[4]);
        w_e22 = TW'(r_a_m[8]);
        w_m01 = NW'(r_a_m[1]);
        w_m02 = NW'(r_a_m[2]);
        w_m10 = NW'(r_a_m[3]);
        w_m12 = NW'(r_a_m[5]);
        w_m20 = NW'(r_a_m[6]);
        w_m21 = NW'(r_a_m[7]);
        w_trace = w_e00 + w_e11 + w_e22;
        n_b_side.degen = 1'b0;
        if (w_trace > 0) begin
            n_b_side.big = BIG_W;
            w_rad        = w_trace + ONE;
            n_b_side.n0  = w_m21 - w_m12;
            n_b_side.n1  = w_m02 - w_m20;
            n_b_side.n2  = w_m10 - w_m01;
        end else if (w_e22 > w_e00 && w_e22 > w_e11) begin
            // largest diagonal is m22: j=0, k=1
            n_b_side.big = BIG_Z;
            w_rad        = w_e22 - w_e00 - w_e11 + ONE;
            n_b_side.n0  = w_m10 - w_m01;
            n_b_side.n1  = w_m02 + w_m20;
            n_b_side.n2  = w_m12 + w_m21;
        end else if (w_e11 > w_e00) begin
            // largest diagonal is m11: j=2, k=0
            n_b_side.big = BIG_Y;
            w_rad        = w_e11 - w_e22 - w_e00 + ONE;
            n_b_side.n0  = w_m02 - w_m20;
            n_b_side.n1  = w_m21 + w_m12;
            n_b_side.n2  = w_m01 + w_m10;
        end else begin
            // largest diagonal is m00: j=1, k=2
            n_b_side.big = BIG_X;
            w_rad        = w_e00 - w_e11 - w_e22 + ONE;
            n_b_side.n0  = w_m21 - w_m12;
            n_b_side.n1  = w_m10 + w_m01;
            n_b_side.n2  = w_m20 + w_m02;
        end
        if (w_rad <= 0) begin
            n_b_side.degen = 1'b1;
        end
        // degenerate items run with a radicand of one LSB; output is masked
        if (n_b_side.degen) begin
            n_b_x = SWE'({{(RW-1){1'b0}}, 1'b1, {FB{1'b0}}});
        end else begin
            n_b_x = SWE'({w_rad[RW-1:0], {FB{1'b0}}});
        end
    end

    // ---------------- square root pipeline, one bit per stage ----------------
    logic              r_s_valid [0:RTW];
    logic [SWE-1:0]    r_s_x     [0:RTW];
    logic [REMS-1:0]   r_s_rem   [0:RTW];
    logic [RTW-1:0]    r_s_root  [0:RTW];
    t_side             r_s_side  [0:RTW];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int t = 0; t <= RTW; t++) begin
                r_s_valid[t] <= 1'b0;
            end
        end else if (w_adv) begin
            r_s_valid[0] <= r_a_valid;
            for (int t = 0; t < RTW; t++) begin
                r_s_valid[t+1] <= r_s_valid[t];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        logic [REMS-1:0] v_rem;
        logic [REMS-1:0] v_trial;
        if (w_adv) begin
            r_s_x[0]    <= n_b_x;
            r_s_rem[0]  <= '0;
            r_s_root[0] <= '0;
            r_s_side[0] <= n_b_side;
            for (int t = 0; t < RTW; t++) begin
                v_rem   = {r_s_rem[t][REMS-3:0], r_s_x[t][SWE-1 -: 2]};
                v_trial = {r_s_root[t], 2'b01};
                r_s_x[t+1]    <= {r_s_x[t][SWE-3:0], 2'b00};
                r_s_side[t+1] <= r_s_side[t];
                if (v_rem >= v_trial) begin
                    r_s_rem[t+1]  <= v_rem - v_trial;
                    r_s_root[t+1] <= {r_s_root[t][RTW-2:0], 1'b1};
                end else begin
                    r_s_rem[t+1]  <= v_rem;
                    r_s_root[t+1] <= {r_s_root[t][RTW-2:0], 1'b0};
                end
            end
        end
    end

    // ---------------- divider setup ----------------
    logic [RTW:0]         w_big_sum;
    logic [DW-1:0]        w_big_val;
    logic [DSW-1:0]       w_div;
    logic [DVW-1:0]       w_num [0:2];
    logic [2:0]           w_neg;
    logic signed [NW-1:0] w_n   [0:2];
    logic [NW-1:0]        w_mag;

    always_comb begin
        w_big_sum = ({1'b0, r_s_root[RTW]} + (RTW+1)'(1)) >> 1;
        if (DVW'(w_big_sum) > SAT_POS) begin
            w_big_val = SAT_POS[DW-1:0];
        end else begin
            w_big_val = DW'(w_big_sum);
        end
        w_div = {r_s_root[RTW], 1'b0};
        w_n[0] = r_s_side[RTW].n0;
        w_n[1] = r_s_side[RTW].n1;
        w_n[2] = r_s_side[RTW].n2;
        for (int l = 0; l < 3; l++) begin
            w_neg[l] = w_n[l][NW-1];
            w_mag    = w_neg[l] ? NW'(-w_n[l]) : NW'(w_n[l]);
            w_num[l] = DVW'({w_mag, {FB{1'b0}}}) + DVW'(r_s_root[RTW]);
        end
    end

    // ---------------- divider pipeline, three lanes, one bit per stage ----------------
    logic              r_d_valid [0:DVW];
    logic [DVW-1:0]    r_d_num   [0:DVW][0:2];
    logic [REMD-1:0]   r_d_rem   [0:DVW][0:2];
    logic [DSW-1:0]    r_d_div   [0:DVW];
    t_dside            r_d_side  [0:DVW];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int t = 0; t <= DVW; t++) begin
                r_d_valid[t] <= 1'b0;
            end
        end else if (w_adv) begin
            r_d_valid[0] <= r_s_valid[RTW];
            for (int t = 0; t < DVW; t++) begin
                r_d_valid[t+1] <= r_d_valid[t];
            end
        end
    end

    // quotient bits shift into the low end of the dividend register
    always_ff @(posedge i_clk) begin
        logic [REMD-1:0] v_rem;
        if (w_adv) begin
            r_d_div[0]          <= w_div;
            r_d_side[0].big     <= r_s_side[RTW].big;
            r_d_side[0].degen   <= r_s_side[RTW].degen;
            r_d_side[0].big_val <= w_big_val;
            r_d_side[0].neg     <= w_neg;
            for (int l = 0; l < 3; l++) begin
                r_d_num[0][l] <= w_num[l];
                r_d_rem[0][l] <= '0;
            end
            for (int t = 0; t < DVW; t++) begin
                r_d_div[t+1]  <= r_d_div[t];
                r_d_side[t+1] <= r_d_side[t];
                for (int l = 0; l < 3; l++) begin
                    v_rem = {r_d_rem[t][l][REMD-2:0], r_d_num[t][l][DVW-1]};
                    if (v_rem >= REMD'(r_d_div[t])) begin
                        r_d_rem[t+1][l] <= v_rem - REMD'(r_d_div[t]);
                        r_d_num[t+1][l] <= {r_d_num[t][l][DVW-2:0], 1'b1};
                    end else begin
                        r_d_rem[t+1][l] <= v_rem;
                        r_d_num[t+1][l] <= {r_d_num[t][l][DVW-2:0], 1'b0};
                    end
                end
            end
        end
    end

    // ---------------- sign, saturation and component placement ----------------
    logic [DW-1:0] w_d  [0:2];
    logic [DW-1:0] n_w, n_x, n_y, n_z;
    logic [DVW-1:0] w_q;

    always_comb begin
        for (int l = 0; l < 3; l++) begin
            w_q = r_d_num[DVW][l];
            if (r_d_side[DVW].neg[l]) begin
                if (w_q >= SAT_NEG) begin
                    w_d[l] = SAT_NEG[DW-1:0];
                end else begin
                    w_d[l] = DW'(-w_q);
                end
            end else begin
                if (w_q > SAT_POS) begin
                    w_d[l] = SAT_POS[DW-1:0];
                end else begin
                    w_d[l] = w_q[DW-1:0];
                end
            end
        end
        case (r_d_side[DVW].big)
            BIG_W: begin
                n_w = r_d_side[DVW].big_val;
                n_x = w_d[0]; n_y = w_d[1]; n_z = w_d[2];
            end
            BIG_X: begin
                n_x = r_d_side[DVW].big_val;
                n_w = w_d[0]; n_y = w_d[1]; n_z = w_d[2];
            end
            BIG_Y: begin
                n_y = r_d_side[DVW].big_val;
                n_w = w_d[0]; n_z = w_d[1]; n_x = w_d[2];
            end
            default: begin
                n_z = r_d_side[DVW].big_val;
                n_w = w_d[0]; n_x = w_d[1]; n_y = w_d[2];
            end
        endcase
        if (r_d_side[DVW].degen) begin
            n_w = '0; n_x = '0; n_y = '0; n_z = '0;
        end
    end

    // ---------------- output register ----------------
    logic          r_out_valid;
    logic [OBW-1:0] r_out_data;
    logic          r_out_degen;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= r_d_valid[DVW];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out_data  <= OBW'({n_z, n_y, n_x, n_w});
            r_out_degen <= r_d_side[DVW].degen;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_degen;

    // ---------------- assertions ----------------
    // a degenerate result carries an all-zero quaternion
    a_degen_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == '0)
        else $error("degenerate result with nonzero quaternion");

    // the trace path never produces a degenerate radicand
    a_trace_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s_valid[0] && r_s_side[0].big == BIG_W |-> !r_s_side[0].degen)
        else $error("trace path flagged degenerate");

    // the root entering the divider is never zero
    a_root_nz: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s_valid[RTW] |-> r_s_root[RTW] != '0)
        else $error("zero divisor reached divider");

    // a stalled output holds its result
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output changed under stall");

endmodule

FILE: test/rotation_matrix_to_quaternion_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rotation_matrix_to_quaternion_unit_tb
// Drives matrices into the converter and checks every quaternion against an
// exact integer predictor. Covers rotations near each Shepperd branch, the
// element extremes and random matrices, with random gaps and back-pressure
// on both streams.
// ----------------------------------------------------------------------------
module rotation_matrix_to_quaternion_unit_tb;

    import rmq_pkg::*;

    localparam int DW      = DATA_WIDTH_DEF;
    localparam int FB      = FRAC_BITS_DEF;
    localparam int IN_W    = ((9*DW+7)/8)*8;
    localparam int OUT_W   = ((4*DW+7)/8)*8;
    localparam int LATENCY = 60;
    localparam longint ONE = 64'sd1 <<< FB;
    localparam longint SMAX = (64'sd1 <<< (DW-1)) - 1;
    localparam longint SMIN = -SMAX - 1;
    localparam int CYCLE_LIMIT = 1000000;

    typedef struct packed {
        logic [DW-1:0] w, x, y, z;
        logic          degen;
    } quat_t;

    logic i_clk = 0;
    logic i_rst_n = 0;
    logic s_axis_tvalid = 0;
    logic s_axis_tready;
    logic [IN_W-1:0] s_axis_tdata = '0;
    logic m_axis_tvalid;
    logic m_axis_tready = 0;
    logic [OUT_W-1:0] m_axis_tdata;
    logic m_axis_tuser;

    quat_t quat_queue[$];
    int errors = 0;
    int sent = 0;
    int degen_seen = 0;
    int checked = 0;
    int cycles = 0;
    bit rx_stall_on = 1;

    rotation_matrix_to_quaternion_unit dut (.*);

    always #5 i_clk = ~i_clk;

    // run-length guard
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", cycles);
            $display("Test completed with failures");
            $finish;
        end
    end

    function automatic longint sat_val(longint v);
        if (v > SMAX) return SMAX;
        if (v < SMIN) return SMIN;
        return v;
    endfunction

    function automatic longint int_sqrt(longint v);
        longint r = 0;
        for (int b = 31; b >= 0; b--) begin
            longint t = r | (64'sd1 <<< b);
            if (t * t <= v) r = t;
        end
        return r;
    endfunction

    // n / (2*root), half away from zero, saturated
    function automatic longint scaled_div(longint n, longint root);
        longint mag = n < 0 ? -n : n;
        longint q = ((mag <<< FB) + root) / (2 * root);
        return sat_val(n < 0 ? -q : q);
    endfunction

    function automatic quat_t predict_quat(logic [IN_W-1:0] d);
        longint m[3][3];
        longint q[4];
        longint tr, rad, root;
        int i, j, k;
        quat_t res;
        for (int n = 0; n < 9; n++)
            m[n/3][n%3] = longint'($signed(d[n*DW +: DW]));
        q = '{0, 0, 0, 0};
        res.degen = 0;
        tr = m[0][0] + m[1][1] + m[2][2];
        if (tr > 0) begin
            root = int_sqrt((tr + ONE) <<< FB);
            q[0] = sat_val((root + 1) >>> 1);
            q[1] = scaled_div(m[2][1] - m[1][2], root);
            q[2] = scaled_div(m[0][2] - m[2][0], root);
            q[3] = scaled_div(m[1][0] - m[0][1], root);
        end else begin
            i = 0;
            if (m[1][1] > m[0][0]) i = 1;
            if (m[2][2] > m[i][i]) i = 2;
            j = (i + 1) % 3;
            k = (j + 1) % 3;
            rad = m[i][i] - m[j][j] - m[k][k] + ONE;
            if (rad <= 0) begin
                res.degen = 1;
            end else begin
                root = int_sqrt(rad <<< FB);
                q[1+i] = sat_val((root + 1) >>> 1);
                q[0]   = scaled_div(m[k][j] - m[j][k], root);
                q[1+j] = scaled_div(m[j][i] + m[i][j], root);
                q[1+k] = scaled_div(m[k][i] + m[i][k], root);
            end
        end
        res.w = q[0][DW-1:0];
        res.x = q[1][DW-1:0];
        res.y = q[2][DW-1:0];
        res.z = q[3][DW-1:0];
        return res;
    endfunction

    // send one matrix request after a random gap; valid stays up after the
    // accept so a zero gap gives back-to-back requests
    task automatic send_matrix(input logic [IN_W-1:0] d);
        int gap = $urandom_range(0, 18);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap > 0) begin
            s_axis_tvalid <= 0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tdata  <= d;
        s_axis_tvalid <= 1;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        quat_queue.push_back(predict_quat(d));
        sent++;
        @(negedge i_clk);
    endtask

    function automatic logic [IN_W-1:0] pack_matrix(longint e[9]);
        logic [IN_W-1:0] d = '0;
        for (int n = 0; n < 9; n++) d[n*DW +: DW] = e[n][DW-1:0];
        return d;
    endfunction

    function automatic longint rnd_elem();
        return longint'($signed(DW'($urandom)));
    endfunction

    // receiver back-pressure
    initial begin
        int stall;
        forever begin
            @(negedge i_clk);
            stall = rx_stall_on ? $urandom_range(0, 18) : 0;
            if (rx_stall_on && $urandom_range(0, 2) == 0) stall = 0;
            if (stall > 0) begin
                m_axis_tready <= 0;
                repeat (stall) @(negedge i_clk);
            end
            m_axis_tready <= 1;
            @(posedge i_clk);
            while (!m_axis_tvalid) @(posedge i_clk);
        end
    end

    // result checker
    always @(posedge i_clk) begin
        quat_t exp_q, got;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = {m_axis_tdata[0 +: DW], m_axis_tdata[DW +: DW],
                   m_axis_tdata[2*DW +: DW], m_axis_tdata[3*DW +: DW], m_axis_tuser};
            if (quat_queue.size() == 0) begin
                $display("%0t: unexpected result %h", $time, got);
                errors++;
            end else begin
                exp_q = quat_queue.pop_front();
                checked++;
                if (got.degen) degen_seen++;
                if (got.w !== exp_q.w) begin
                    $display("%0t: q_w exp %h got %h", $time, exp_q.w, got.w); errors++;
                end
                if (got.x !== exp_q.x) begin
                    $display("%0t: q_x exp %h got %h", $time, exp_q.x, got.x); errors++;
                end
                if (got.y !== exp_q.y) begin
                    $display("%0t: q_y exp %h got %h", $time, exp_q.y, got.y); errors++;
                end
                if (got.z !== exp_q.z) begin
                    $display("%0t: q_z exp %h got %h", $time, exp_q.z, got.z); errors++;
                end
                if (got.degen !== exp_q.degen) begin
                    $display("%0t: degenerate exp %b got %b", $time, exp_q.degen,
                             got.degen);
                    errors++;
                end
            end
        end
    end

    // drop valid and wait until every expected result has been taken
    task automatic wait_drained();
        s_axis_tvalid <= 0;
        @(negedge i_clk);
        while (quat_queue.size() != 0) @(negedge i_clk);
    endtask

    // identity, half-turns about each axis, ties and extremes
    task automatic test_directed();
        longint o = ONE;
        longint mx = SMAX, mn = SMIN;
        send_matrix(pack_matrix('{o, 0, 0, 0, o, 0, 0, 0, o}));
        send_matrix(pack_matrix('{o, 0, 0, 0, -o, 0, 0, 0, -o}));
        send_matrix(pack_matrix('{-o, 0, 0, 0, o, 0, 0, 0, -o}));
        send_matrix(pack_matrix('{-o, 0, 0, 0, -o, 0, 0, 0, o}));
        send_matrix(pack_matrix('{0, -o, 0, o, 0, 0, 0, 0, o}));
        // trace of one LSB, trace of zero
        send_matrix(pack_matrix('{1, 5, -7, 3, 0, 9, -2, 4, 0}));
        send_matrix(pack_matrix('{0, 5, -7, 3, 0, 9, -2, 4, 0}));
        // ties on the diagonal go to the lower index
        send_matrix(pack_matrix('{-o, 100, 200, 300, -o, 400, 500, 600, -o}));
        send_matrix(pack_matrix('{0, 0, 0, 0, 0, 0, 0, 0, 0}));
        // negative and full-scale diagonals (no radicand is degenerate)
        send_matrix(pack_matrix('{-o/2, 1, 2, 3, -o/2, 4, 5, 6, -o/2}));
        send_matrix(pack_matrix('{mn, 1, 1, 1, mn, 1, 1, 1, mn}));
        send_matrix(pack_matrix('{0, 0, 0, 0, mx, 0, 0, 0, mx}));
        // full-scale saturation
        send_matrix(pack_matrix('{mx, mx, mx, mx, mx, mx, mx, mx, mx}));
        send_matrix(pack_matrix('{mn, mn, mn, mn, mn, mn, mn, mn, mn}));
        send_matrix(pack_matrix('{1, mx, mn, mn, 0, mx, mx, mn, 0}));
        send_matrix(pack_matrix('{mx, mn, mx, mn, mn, mn, mx, mx, mn}));
        send_matrix(pack_matrix('{-1, mx, mn, mn, -1, mx, mx, mn, mx}));
        send_matrix(pack_matrix('{-1, -1, -1, -1, -1, -1, -1, -1, -1}));
    endtask

    // random full-range, scaled-down and near-rotation matrices (small perturbation of signed permutations)
    task automatic test_random(int count);
        longint e[9];
        int kind;
        for (int t = 0; t < count; t++) begin
            kind = $urandom_range(0, 9);
            for (int n = 0; n < 9; n++) begin
                if (kind < 3)
                    e[n] = rnd_elem();
                else if (kind < 7)
                    e[n] = longint'($signed(DW'($urandom))) >>> $urandom_range(1, 3);
                else
                    e[n] = longint'($urandom_range(0, 200)) - 100;
            end
            if (kind >= 7) begin
                int p = $urandom_range(0, 2);
                for (int r = 0; r < 3; r++)
                    e[r*3 + (r + p) % 3] += $urandom_range(0, 1) ? ONE : -ONE;
            end
            send_matrix(pack_matrix(e));
            if (t == count / 2) wait_drained();
        end
    endtask

    // back-to-back requests with the receiver always ready
    task automatic test_streaming(int count);
        longint e[9];
        rx_stall_on = 0;
        wait_drained();
        for (int t = 0; t < count; t++) begin
            for (int n = 0; n < 9; n++) e[n] = rnd_elem();
            s_axis_tdata  <= pack_matrix(e);
            s_axis_tvalid <= 1;
            @(posedge i_clk);
            while (!s_axis_tready) @(posedge i_clk);
            quat_queue.push_back(predict_quat(pack_matrix(e)));
            sent++;
            @(negedge i_clk);
        end
        rx_stall_on = 1;
    endtask

    initial begin
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1;
        test_directed();
        test_random(1000);
        test_streaming(200);
        wait_drained();
        repeat (LATENCY + 10) @(negedge i_clk);
        $display("Sent %0d matrices, checked %0d quaternions (%0d degenerate).",
                 sent, checked, degen_seen);
        if (errors == 0 && quat_queue.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
